>>> rtl/wfc_pkg.sv
// ---------------------------------------------------------------------------
// Word frequency counter package
// Shared constants and types for the word frequency counter.
// ---------------------------------------------------------------------------
`default_nettype none
package wfc_pkg;
   localparam int unsigned ENTRIES_DEFAULT    = 256;
   localparam int unsigned WORD_MAX_DEFAULT   = 19;
   localparam int unsigned COUNT_BITS_DEFAULT = 16;
   localparam int unsigned OUT_COUNT_BITS     = 16;
   localparam int unsigned LETTER_BITS        = 5;
   localparam int unsigned LEN_BITS           = 5;
   localparam logic [31:0] HASH_SEED          = 32'd5381;
   localparam logic [7:0]  LETTER_LOW         = 8'd97;
   localparam logic [7:0]  LETTER_HIGH        = 8'd122;

   typedef struct packed {
      logic       start;
      logic       query;
      logic [31:0] hash;
   } probe_cmd_type;

   typedef struct packed {
      logic [OUT_COUNT_BITS-1:0] word_count;
      logic                      is_query;
      logic                      found;
      logic                      table_full;
   } probe_rsp_type;
endpackage
`default_nettype wire

>>> rtl/wfc_letter_cell.sv
// ---------------------------------------------------------------------------
// Letter cell
// One position of the current word; the row shifts letters in towards the
// tail so that the newest letter sits in cell zero.
// ---------------------------------------------------------------------------
`default_nettype none
module wfc_letter_cell (
   input  wire                        clock,
   input  wire                        shift_en,
   input  wire [wfc_pkg::LETTER_BITS-1:0] letter_in,
   output logic [wfc_pkg::LETTER_BITS-1:0] letter_out
);
   import wfc_pkg::*;
   logic [LETTER_BITS-1:0] letter_ff;
   always_ff @(posedge clock) begin
      if (shift_en) begin
         letter_ff <= letter_in;
      end
   end
   assign letter_out = letter_ff;
endmodule
`default_nettype wire

>>> rtl/wfc_table.sv
// ---------------------------------------------------------------------------
// Key table
// Linearly probed key store. Each probe step reads one slot; the key
// compare walks letter by letter over the stored key.
// ---------------------------------------------------------------------------
`default_nettype none
module wfc_table #(
   parameter int unsigned ENTRIES    = wfc_pkg::ENTRIES_DEFAULT,
   parameter int unsigned WORD_MAX   = wfc_pkg::WORD_MAX_DEFAULT,
   parameter int unsigned COUNT_BITS = wfc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wfc_pkg::probe_cmd_type       cmd,
   input  wire [wfc_pkg::LEN_BITS-1:0]  word_len,
   input  wire [wfc_pkg::LETTER_BITS*WORD_MAX-1:0] word_letters,
   output logic                         idle,
   output logic                         done,
   output wfc_pkg::probe_rsp_type       rsp
);
   import wfc_pkg::*;
   localparam int unsigned SB  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned PB  = $clog2(ENTRIES + 1);
   localparam int unsigned LIB = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
   localparam int unsigned KB  = $clog2(ENTRIES * WORD_MAX);
   localparam logic [COUNT_BITS-1:0] TMAX = {COUNT_BITS{1'b1}};

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_READ  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_CMP   = 6'b010000,
      ST_WRITE = 6'b100000
   } state_type;

   logic [LEN_BITS-1:0]   key_len_mem [ENTRIES];
   logic [COUNT_BITS-1:0] tally_mem   [ENTRIES];
   logic [LETTER_BITS-1:0] key_mem    [ENTRIES*WORD_MAX];
   logic                  valid_mem   [ENTRIES];

   state_type state_ff, state_in;
   logic [SB-1:0]  slot_ff, slot_in;
   logic [PB-1:0]  tries_ff, tries_in;
   logic [LIB-1:0] pos_ff, pos_in;
   logic           query_ff, query_in;
   logic [LEN_BITS-1:0]   rd_len_ff;
   logic [COUNT_BITS-1:0] rd_tally_ff;
   logic                  rd_valid_ff;
   logic [LETTER_BITS-1:0] rd_key_ff;
   logic                  done_ff, done_in;
   probe_rsp_type         rsp_ff, rsp_in;
   logic                  wr_en, key_wr_en, clr_en, rd_key_en;
   logic [COUNT_BITS-1:0] wr_tally;
   logic [KB-1:0]         key_rd_addr, key_wr_addr;
   logic [LETTER_BITS-1:0] own_letter, wr_letter;
   logic [COUNT_BITS-1:0] tally_inc;
   logic [SB-1:0]         slot_next;

   assign slot_next = (slot_ff == SB'(ENTRIES - 1)) ? '0 : slot_ff + 1'b1;
   // The key letter for the next compare is fetched ahead, addressed by pos_in.
   assign key_rd_addr = KB'(slot_ff * WORD_MAX + pos_in);
   // Letters are stored newest first: position p is letter len-1-p.
   assign own_letter = word_letters[pos_ff*LETTER_BITS +: LETTER_BITS];
   assign tally_inc = (rd_tally_ff == TMAX) ? rd_tally_ff : rd_tally_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (clr_en || wr_en) begin
         valid_mem[slot_ff] <= wr_en;
      end
      if (wr_en) begin
         tally_mem[slot_ff]   <= wr_tally;
         key_len_mem[slot_ff] <= word_len;
      end
      if (key_wr_en) begin
         key_mem[key_wr_addr] <= wr_letter;
      end
      rd_len_ff   <= key_len_mem[slot_ff];
      rd_tally_ff <= tally_mem[slot_ff];
      rd_valid_ff <= valid_mem[slot_ff];
      if (rd_key_en) begin
         rd_key_ff <= key_mem[key_rd_addr];
      end
   end

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      tries_in  = tries_ff;
      pos_in    = pos_ff;
      query_in  = query_ff;
      done_in   = 1'b0;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      key_wr_en = 1'b0;
      clr_en    = 1'b0;
      rd_key_en = 1'b0;
      wr_tally  = tally_inc;
      key_wr_addr = KB'(slot_ff * WORD_MAX + pos_ff);
      wr_letter   = own_letter;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_en  = 1'b1;
            slot_in = slot_next;
            if (slot_ff == SB'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.start) begin
               slot_in  = SB'(cmd.hash % ENTRIES);
               query_in = cmd.query;
               tries_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            pos_in    = '0;
            rd_key_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (!rd_valid_ff) begin
               rsp_in.is_query   = query_ff;
               rsp_in.found      = 1'b0;
               rsp_in.table_full = 1'b0;
               if (query_ff) begin
                  rsp_in.word_count = '0;
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  rsp_in.word_count = OUT_COUNT_BITS'(1);
                  pos_in   = '0;
                  state_in = ST_WRITE;
               end
            end else if (rd_len_ff == word_len) begin
               state_in  = ST_CMP;
               pos_in    = pos_ff + 1'b1;
               rd_key_en = 1'b1;
               if (rd_key_ff != own_letter) begin
                  state_in = ST_READ;
               end else if (LEN_BITS'(pos_ff) + 1'b1 == word_len) begin
                  state_in = ST_CMP;
               end
               if (rd_key_ff != own_letter ||
                   LEN_BITS'(pos_ff) + 1'b1 != word_len) begin
                  if (rd_key_ff != own_letter) begin
                     tries_in = tries_ff + 1'b1;
                     slot_in  = slot_next;
                     if (tries_ff + 1'b1 == PB'(ENTRIES)) begin
                        rsp_in.is_query   = query_ff;
                        rsp_in.found      = 1'b0;
                        rsp_in.table_full = !query_ff;
                        rsp_in.word_count = '0;
                        done_in  = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_CHECK;
                  end
               end
            end else begin
               tries_in = tries_ff + 1'b1;
               slot_in  = slot_next;
               state_in = ST_READ;
               if (tries_ff + 1'b1 == PB'(ENTRIES)) begin
                  rsp_in.is_query   = query_ff;
                  rsp_in.found      = 1'b0;
                  rsp_in.table_full = !query_ff;
                  rsp_in.word_count = '0;
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CMP: begin
            rsp_in.is_query   = query_ff;
            rsp_in.found      = 1'b1;
            rsp_in.table_full = 1'b0;
            if (query_ff) begin
               rsp_in.word_count = OUT_COUNT_BITS'(rd_tally_ff);
            end else begin
               rsp_in.word_count = OUT_COUNT_BITS'(tally_inc);
               wr_en = 1'b1;
            end
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WRITE: begin
            key_wr_en = 1'b1;
            pos_in    = pos_ff + 1'b1;
            if (LEN_BITS'(pos_ff) + 1'b1 >= word_len) begin
               wr_en    = 1'b1;
               wr_tally = COUNT_BITS'(1);
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         slot_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         done_ff  <= done_in;
      end
      tries_ff <= tries_in;
      pos_ff   <= pos_in;
      query_ff <= query_in;
      rsp_ff   <= rsp_in;
   end

   assign idle = (state_ff == ST_IDLE);
   assign done = done_ff;
   assign rsp  = rsp_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == ST_IDLE) else $error("probe started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held for two cycles");
   a_full_text: assert property (@(posedge clock) disable iff (reset)
      done && rsp.table_full |-> !rsp.is_query && !rsp.found)
      else $error("table full on a query or a found word");
`endif
endmodule
`default_nettype wire

>>> rtl/word_frequency_counter_top.sv
// ---------------------------------------------------------------------------
// Word frequency counter
// Counts lower-case words in a byte stream and answers count queries.
// ---------------------------------------------------------------------------
//  channel | direction | content
//  req     | in        | tdata char_code, tuser func
//  rsp     | out       | tdata word_count, found, truncated, table_full;
//          |           | tuser is_query
//
// A letter, or a separator with no word pending, is taken without a probe.
// A separator that ends a word starts a probe: each visited slot is read
// and then checked letter by letter, a hit adds an update step and an
// insert writes the key letter by letter. The result is registered in the
// table and again in the output register; the next transfer waits for done.
// After reset the valid marks are cleared and no transfer is taken until
// the clear has run over every slot. A second finished word may wait behind
// the output register; while it does, the input stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module word_frequency_counter_top #(
   parameter int unsigned ENTRIES    = wfc_pkg::ENTRIES_DEFAULT,
   parameter int unsigned WORD_MAX   = wfc_pkg::WORD_MAX_DEFAULT,
   parameter int unsigned COUNT_BITS = wfc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // char_code
   input  wire         req_tuser,   // func
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // word_count, found, truncated, table_full,
                                    // zero fill
   output logic        rsp_tuser    // is_query
);
   import wfc_pkg::*;

   wire  [LETTER_BITS*(WORD_MAX+1)-1:0] row;
   logic [LETTER_BITS*WORD_MAX-1:0] letters;
   logic [LEN_BITS-1:0]  total_ff;
   logic [31:0]          hash_ff;
   logic                 over_ff, busy_ff, clr_done_ff;
   logic                 trunc_hold_ff;
   logic                 out_valid_ff, hold_valid_ff;
   logic [24:0]          out_data_ff, hold_data_ff, result_data;
   logic                 accept, is_letter, shift_en, tbl_done, tbl_idle, out_take;
   probe_cmd_type        cmd;
   probe_rsp_type        trsp;
   logic [LETTER_BITS-1:0] new_letter;

   assign accept    = req_tvalid && req_tready;
   assign out_take  = out_valid_ff && rsp_tready;
   assign is_letter = req_tdata >= LETTER_LOW && req_tdata <= LETTER_HIGH;
   assign shift_en  = accept && is_letter && total_ff < LEN_BITS'(WORD_MAX);
   assign new_letter = LETTER_BITS'(req_tdata - LETTER_LOW);
   // Every transfer needs the clear finished, no probe busy and no held result.
   assign req_tready = clr_done_ff && !busy_ff && !hold_valid_ff;

   // Cell zero holds the newest letter; the word is reversed in the row.
   assign row[LETTER_BITS-1:0] = new_letter;
   genvar gi;
   generate
      for (gi = 0; gi < WORD_MAX; gi++) begin : g_cell
         wfc_letter_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .letter_in (row[gi*LETTER_BITS +: LETTER_BITS]),
            .letter_out(row[(gi+1)*LETTER_BITS +: LETTER_BITS])
         );
      end
   endgenerate
   assign letters = row[LETTER_BITS*(WORD_MAX+1)-1:LETTER_BITS];

   assign cmd.start = accept && !is_letter && total_ff != '0;
   assign cmd.query = req_tuser;
   assign cmd.hash  = hash_ff;

   wfc_table #(.ENTRIES(ENTRIES), .WORD_MAX(WORD_MAX), .COUNT_BITS(COUNT_BITS)) u_table (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .word_len    (total_ff),
      .word_letters(letters),
      .idle        (tbl_idle),
      .done        (tbl_done),
      .rsp         (trsp)
   );

   assign result_data = {trsp.is_query, 5'b0, trsp.table_full, trunc_hold_ff,
                         trsp.found, trsp.word_count};

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         hash_ff       <= HASH_SEED;
         over_ff       <= 1'b0;
         busy_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         clr_done_ff   <= 1'b0;
      end else begin
         if (!clr_done_ff && tbl_idle) begin
            clr_done_ff <= 1'b1;
         end
         if (shift_en) begin
            total_ff <= total_ff + 1'b1;
            hash_ff  <= (hash_ff << 5) + hash_ff + 32'(req_tdata);
         end else if (accept && is_letter) begin
            over_ff <= 1'b1;
         end
         if (cmd.start) begin
            busy_ff       <= 1'b1;
            trunc_hold_ff <= over_ff;
         end
         if (tbl_done) begin
            busy_ff  <= 1'b0;
            total_ff <= '0;
            hash_ff  <= HASH_SEED;
            over_ff  <= 1'b0;
         end
         if (out_take) begin
            if (hold_valid_ff) begin
               out_data_ff   <= hold_data_ff;
               hold_valid_ff <= 1'b0;
            end else if (tbl_done) begin
               out_data_ff <= result_data;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (tbl_done) begin
            if (out_valid_ff) begin
               hold_valid_ff <= 1'b1;
               hold_data_ff  <= result_data;
            end else begin
               out_valid_ff <= 1'b1;
               out_data_ff  <= result_data;
            end
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff[23:0];
   assign rsp_tuser  = out_data_ff[24];

`ifndef SYNTH
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      tbl_done |-> !hold_valid_ff) else $error("result overwritten");
   a_hold_order: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> out_valid_ff) else $error("held result without output");
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_tready) else $error("transfer taken during probe");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= LEN_BITS'(WORD_MAX)) else $error("word length out of range");
`endif
endmodule
`default_nettype wire
